[hdl/dht_pkg.sv]
// ----------------------------------------------------------------------------
// dht_pkg
// Types, codes and constants shared by the double hashing table block.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned KeyBytesDefault   = 8;
  localparam int unsigned ValueBitsDefault  = 32;
  localparam int unsigned SizeWidth         = 11;
  localparam logic [SizeWidth-1:0] SizeReset = 11'd1024;

  localparam logic [1:0] ActInsert  = 2'd0;
  localparam logic [1:0] ActSearch  = 2'd1;
  localparam logic [1:0] ActRemove  = 2'd2;
  localparam logic [1:0] ActUnknown = 2'd3;

  localparam logic [1:0] SlotEmpty   = 2'd0;
  localparam logic [1:0] SlotUsed    = 2'd1;
  localparam logic [1:0] SlotDeleted = 2'd2;

  localparam logic [2:0] ResInserted = 3'd0;
  localparam logic [2:0] ResFound    = 3'd1;
  localparam logic [2:0] ResNotFound = 3'd2;
  localparam logic [2:0] ResRemoved  = 3'd3;
  localparam logic [2:0] ResFull     = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot_index;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD1, ST_MOD2, ST_READ, ST_WAIT,
    ST_CHECK, ST_STEP, ST_DONE
  } state_t;

endpackage

[hdl/dht_ram.sv]
// ----------------------------------------------------------------------------
// dht_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/dht_mod.sv]
// ----------------------------------------------------------------------------
// dht_mod
// Restoring remainder unit: one quotient bit per cycle of a 64-bit dividend
// by a narrow divisor.
// ----------------------------------------------------------------------------
module dht_mod import dht_pkg::*; #(
  parameter int unsigned DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] remainder
);

  logic [63:0]   shreg;
  logic [DW:0]   rem;
  logic [6:0]    count;
  logic [DW:0]   trial;

  assign trial     = {rem[DW-1:0], shreg[63]};
  assign busy      = (count != 7'd0);
  assign remainder = rem[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 7'd0;
    end else if (start) begin
      count <= 7'd64;
    end else if (busy) begin
      count <= count - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[62:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
      end else begin
        rem <= trial;
      end
    end
  end

endmodule

[hdl/double_hash_table.sv]
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressing hash table with double hashing and a per-slot status.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake
//  req      | in        | req_valid / req_ready, payload req_t
//  rsp      | out       | rsp_valid / rsp_ready, payload rsp_t
//  cfg      | in        | cfg_valid / cfg_ready, slot count write data
//
// One request at a time. A request is hashed a key byte at a time (a separate
// shift-add for each of the two hashes), then the two remainders are taken in
// turn in the shared bit-serial divider, then each probe runs through READ,
// WAIT, CHECK and maybe STEP. After reset a clearing pass marks all TABLE_DEPTH
// slots empty; no request is taken meanwhile. A stalled result holds the block.
// ----------------------------------------------------------------------------
module double_hash_table import dht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault,
  parameter int unsigned KEY_BYTES   = KeyBytesDefault,
  parameter int unsigned VALUE_BITS  = ValueBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SizeWidth-1:0] cfg_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DW = CW;
  localparam int unsigned KW = KEY_BYTES * 8;
  localparam int unsigned LW = $clog2(KEY_BYTES + 1);

  state_t state, state_next;

  logic [SizeWidth-1:0] size_cfg;
  logic [CW-1:0]  size_use;
  logic [1:0]     action;
  logic [KW-1:0]  key;
  logic [LW-1:0]  klen;
  logic [VALUE_BITS-1:0] value;
  logic [63:0]    h1, h2;
  logic [LW-1:0]  bcnt;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  step;
  logic [CW-1:0]  probes;
  logic [AW-1:0]  clr_addr;
  rsp_t           rsp_reg;

  // Shared divider.
  logic          div_start, div_busy;
  logic [63:0]   div_dividend;
  logic [DW-1:0] div_divisor, div_rem;

  dht_mod #(.DW(DW)) u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .busy(div_busy), .remainder(div_rem)
  );

  // Slot memories.
  logic          st_we, kv_we;
  logic [AW-1:0] mem_addr;
  logic [1:0]    st_wdata, st_rdata;
  logic [KW+LW-1:0] kv_rdata;
  logic [VALUE_BITS-1:0] pl_rdata;

  dht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_status (
    .clk(clk), .we(st_we), .addr(mem_addr), .wdata(st_wdata), .rdata(st_rdata)
  );
  dht_ram #(.WIDTH(KW + LW), .DEPTH(TABLE_DEPTH)) u_key (
    .clk(clk), .we(kv_we), .addr(mem_addr), .wdata({key, klen}), .rdata(kv_rdata)
  );
  dht_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_payload (
    .clk(clk), .we(kv_we), .addr(mem_addr), .wdata(value), .rdata(pl_rdata)
  );

  // Size in use saturated to 2..TABLE_DEPTH.
  always_comb begin
    if (size_cfg < SizeWidth'(2)) begin
      size_use = CW'(2);
    end else if ({1'b0, size_cfg} > (SizeWidth + 1)'(TABLE_DEPTH)) begin
      size_use = CW'(TABLE_DEPTH);
    end else begin
      size_use = CW'(size_cfg);
    end
  end

  // Request fields after length saturation and masking.
  logic [LW-1:0] in_len;
  logic [KW-1:0] in_key;
  always_comb begin
    if (req.key_length == 4'd0) begin
      in_len = LW'(1);
    end else if (32'(req.key_length) > KEY_BYTES) begin
      in_len = LW'(KEY_BYTES);
    end else begin
      in_len = LW'(req.key_length);
    end
    for (int b = 0; b < KEY_BYTES; b++) begin
      in_key[b*8 +: 8] = (b < 32'(in_len)) ? req.key_bytes[b*8 +: 8] : 8'd0;
    end
  end

  logic [7:0] cur_byte;
  assign cur_byte = key[bcnt[$clog2(KEY_BYTES > 1 ? KEY_BYTES : 2)-1:0] * 8 +: 8];

  logic match;
  assign match = (st_rdata == SlotUsed) && (kv_rdata[LW-1:0] == klen)
              && (kv_rdata[KW+LW-1:LW] == key);

  logic [AW:0] idx_sum;
  assign idx_sum = {1'b0, idx} + {1'b0, step};

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_valid = (state == ST_DONE);
  assign rsp       = rsp_reg;

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = h1;
    div_divisor  = DW'(size_use);
    st_we        = 1'b0;
    kv_we        = 1'b0;
    st_wdata     = SlotUsed;
    mem_addr     = idx;
    case (state)
      ST_CLEAR: begin
        mem_addr = clr_addr;
        st_we    = 1'b1;
        st_wdata = SlotEmpty;
        if (clr_addr == AW'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.action == ActUnknown) ? ST_DONE : ST_HASH;
        end
      end
      ST_HASH: begin
        if (bcnt == klen) begin
          div_start  = 1'b1;
          state_next = ST_MOD1;
        end
      end
      ST_MOD1: begin
        if (!div_busy) begin
          div_start    = 1'b1;
          div_dividend = h2;
          div_divisor  = DW'(size_use - CW'(1));
          state_next   = ST_MOD2;
        end
      end
      ST_MOD2: begin
        // The divider reads its divisor on every step, so keep the step modulus.
        div_divisor = DW'(size_use - CW'(1));
        if (!div_busy) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_WAIT;
      ST_WAIT:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (action == ActInsert) begin
          if (st_rdata != SlotUsed) begin
            st_we = 1'b1;
            kv_we = 1'b1;
            state_next = ST_DONE;
          end else begin
            state_next = ST_STEP;
          end
        end else if (st_rdata == SlotEmpty) begin
          state_next = ST_DONE;
        end else if (match) begin
          if (action == ActRemove) begin
            st_we    = 1'b1;
            st_wdata = SlotDeleted;
          end
          state_next = ST_DONE;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = (probes == size_use) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      size_cfg <= SizeReset;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) size_cfg <= cfg_data;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        action  <= req.action;
        key     <= in_key;
        klen    <= in_len;
        value   <= VALUE_BITS'(req.entry_value);
        h1      <= '0;
        h2      <= '0;
        bcnt    <= '0;
        probes  <= '0;
        rsp_reg <= '{status: ResNotFound, found_value: 32'd0, slot_index: 10'd0};
      end
      ST_HASH: begin
        if (bcnt != klen) begin
          h1   <= (h1 << 5) + h1 + 64'(cur_byte);
          h2   <= (h2 << 4) + h2 + 64'(cur_byte);
          bcnt <= bcnt + LW'(1);
        end
      end
      ST_MOD1: if (!div_busy) idx <= AW'(div_rem);
      ST_MOD2: if (!div_busy) step <= AW'(div_rem + DW'(1));
      ST_READ: probes <= probes + CW'(1);
      ST_CHECK: begin
        if (action == ActInsert) begin
          if (st_rdata != SlotUsed) begin
            rsp_reg <= '{status: ResInserted, found_value: 32'd0,
                         slot_index: 10'(idx)};
          end
        end else if (st_rdata != SlotEmpty && match) begin
          if (action == ActSearch) begin
            rsp_reg <= '{status: ResFound, found_value: 32'(pl_rdata),
                         slot_index: 10'(idx)};
          end else begin
            rsp_reg <= '{status: ResRemoved, found_value: 32'd0,
                         slot_index: 10'(idx)};
          end
        end
      end
      ST_STEP: begin
        if ((AW+1)'(idx_sum) >= (AW+1)'(size_use)) begin
          idx <= AW'(idx_sum - (AW+1)'(size_use));
        end else begin
          idx <= AW'(idx_sum);
        end
        if (probes == size_use) begin
          rsp_reg <= '{status: ResFull, found_value: 32'd0, slot_index: 10'd0};
        end
      end
      default: ;
    endcase
  end

endmodule

[hdl/dht_checker.sv]
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks on the double hashing table.
// ----------------------------------------------------------------------------
module dht_port_checks import dht_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // One request at a time: no new request while a result waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ResFull) else $error("bad status code");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ResFound |-> rsp.found_value == 32'd0)
    else $error("found_value not zero");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ResNotFound || rsp.status == ResFull)
    |-> rsp.slot_index == 10'd0) else $error("slot_index not zero");

endmodule

bind double_hash_table dht_port_checks u_port_checks (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

[verif/dht_checker.sv]
// ----------------------------------------------------------------------------
// dht_checker
// Watches the request, result and table size channels of the double hashing
// table. It keeps its own copy of the slot store, predicts the result of
// every accepted request and compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module dht_checker import dht_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  req_t                 req,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rsp_t                 rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [SizeWidth-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = TableDepthDefault;

  logic [1:0]           slot_state [Depth];
  logic [63:0]          slot_key   [Depth];
  int unsigned          slot_len   [Depth];
  logic [31:0]          slot_value [Depth];
  logic [SizeWidth-1:0] size_reg;
  rsp_t                 expected_results [$];
  int                   reported;

  assign pending_count = expected_results.size();

  function automatic rsp_t predict_table_op(req_t r);
    int unsigned len, size, idx, step;
    logic [63:0] k, mask, h1, h2;
    rsp_t res;
    res = '0;
    len = r.key_length;
    if (len < 1) len = 1;
    if (len > KeyBytesDefault) len = KeyBytesDefault;
    mask = (len >= 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
    k = r.key_bytes & mask;
    if (r.action != ActInsert && r.action != ActSearch && r.action != ActRemove) begin
      res.status = ResNotFound;
      return res;
    end
    size = size_reg;
    if (size < 2) size = 2;
    if (size > Depth) size = Depth;
    h1 = '0;
    h2 = '0;
    for (int i = 0; i < len; i++) begin
      h1 = h1 * 64'd33 + 64'(k[8*i +: 8]);
      h2 = h2 * 64'd17 + 64'(k[8*i +: 8]);
    end
    idx = int'(h1 % 64'(size));
    step = 1 + int'(h2 % 64'(size - 1));
    for (int n = 0; n < size; n++) begin
      if (r.action == ActInsert) begin
        if (slot_state[idx] != SlotUsed) begin
          slot_state[idx] = SlotUsed;
          slot_key[idx] = k;
          slot_len[idx] = len;
          slot_value[idx] = r.entry_value;
          res.status = ResInserted;
          res.slot_index = 10'(idx);
          return res;
        end
      end else begin
        if (slot_state[idx] == SlotEmpty) begin
          res.status = ResNotFound;
          return res;
        end
        if (slot_state[idx] == SlotUsed && slot_len[idx] == len && slot_key[idx] == k) begin
          if (r.action == ActSearch) begin
            res.status = ResFound;
            res.found_value = slot_value[idx];
          end else begin
            slot_state[idx] = SlotDeleted;
            res.status = ResRemoved;
          end
          res.slot_index = 10'(idx);
          return res;
        end
      end
      idx = (idx + step) % size;
    end
    res.status = ResFull;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < Depth; i++) slot_state[i] = SlotEmpty;
      size_reg = SizeReset;
      expected_results.delete();
      fail_count = 0;
      reported = 0;
    end else begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      // The result side is checked first; the block holds one request at a time.
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("Unexpected result transfer: status %0d value %h slot %0d",
                     rsp.status, rsp.found_value, rsp.slot_index);
          end
        end else begin
          exp_rsp = expected_results.pop_front();
          if (rsp.status != exp_rsp.status || rsp.found_value != exp_rsp.found_value ||
              rsp.slot_index != exp_rsp.slot_index) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("Mismatch: expected status %0d value %h slot %0d, got %0d %h %0d",
                       exp_rsp.status, exp_rsp.found_value, exp_rsp.slot_index,
                       rsp.status, rsp.found_value, rsp.slot_index);
            end
          end
        end
      end
      if (req_valid && req_ready) expected_results.push_back(predict_table_op(req));
    end
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the double hashing table with directed and random requests over a
// range of table sizes, with random gaps on both sides, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  import dht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 60000;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_t                 rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SizeWidth-1:0] cfg_data;
  int                   fail_count;
  int                   pending_count;
  int                   idle_cycles;
  int                   results_seen;
  bit                   sender_no_gaps;
  logic [63:0]          key_pool [64];
  logic [3:0]           len_pool [64];

  double_hash_table u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  dht_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Valid stays high across back-to-back transfers when no gap is drawn.
  task automatic send_request(logic [1:0] act, logic [63:0] kb, logic [3:0] kl,
                              logic [31:0] val);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{action: act, key_bytes: kb, key_length: kl, entry_value: val};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(logic [SizeWidth-1:0] size);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Key from the pool, with random junk above the key length.
  task automatic send_pool_request(logic [1:0] act, int slot);
    int unsigned len;
    logic [63:0] mask;
    len = len_pool[slot];
    if (len < 1) len = 1;
    if (len > 8) len = 8;
    mask = (len >= 8) ? '1 : (64'd1 << (8 * len)) - 64'd1;
    send_request(act, (key_pool[slot] & mask) | ({$urandom, $urandom} & ~mask),
                 len_pool[slot], $urandom);
  endtask

  task automatic random_phase(logic [SizeWidth-1:0] size, int items, int keys,
                              bit pause_midway);
    int roll;
    int slot;
    write_size(size);
    sender_no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < keys; i++) begin
      key_pool[i] = {$urandom, $urandom};
      roll = $urandom_range(0, 9);
      len_pool[i] = (roll == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    end
    for (int i = 0; i < items; i++) begin
      if (pause_midway && i == items / 2) wait_drained();
      roll = $urandom_range(0, 99);
      slot = $urandom_range(0, keys - 1);
      if (roll < 5)
        send_request(ActUnknown, {$urandom, $urandom}, 4'($urandom), $urandom);
      else if (roll < 10)
        send_request(2'($urandom_range(0, 2)), {$urandom, $urandom}, 4'($urandom), $urandom);
      else if (roll < 45) send_pool_request(ActInsert, slot);
      else if (roll < 80) send_pool_request(ActSearch, slot);
      else send_pool_request(ActRemove, slot);
    end
  endtask

  // Result side: a random hold-off per result, none in every fourth run of 100 results, and one long stretch.
  initial begin
    int w;
    rsp_ready <= 1'b1;
    results_seen = 0;
    @(posedge clk);
    forever begin
      w = (results_seen == 150) ? 400 : $urandom_range(0, 16);
      if ((results_seen / 100) % 4 == 3) w = 0;
      if (w > 0) begin
        rsp_ready <= 1'b0;
        repeat (w) @(posedge clk);
        rsp_ready <= 1'b1;
      end
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      results_seen++;
    end
  end

  // Counts cycles without any transfer; the clearing pass fits well inside.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    sender_no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset size: extreme keys, length saturation, duplicates and removal.
    send_request(ActInsert, '1, 4'd8, '1);
    send_request(ActSearch, '1, 4'd8, '0);
    send_request(ActInsert, 64'h0, 4'd0, 32'h0);
    send_request(ActSearch, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, '0);
    send_request(ActInsert, 64'h0000_0041_4141_4141, 4'd15, 32'h1234_5678);
    send_request(ActSearch, 64'hFF00_0041_4141_4141, 4'd8, '0);
    send_request(ActSearch, 64'h0000_0041_4141_4141, 4'd7, '0);
    send_request(ActInsert, '1, 4'd8, 32'hA5A5_A5A5);
    send_request(ActRemove, '1, 4'd8, '0);
    send_request(ActSearch, '1, 4'd8, '0);
    send_request(ActRemove, '1, 4'd8, '0);
    send_request(ActRemove, '1, 4'd8, '0);
    send_request(ActUnknown, '1, 4'd8, '1);
    send_request(ActSearch, 64'h6B_6579, 4'd3, '0);

    // Two slots: fill, overflow, search and remove through deleted slots.
    write_size(11'd2);
    send_request(ActInsert, 64'h61, 4'd1, 32'd1);
    send_request(ActInsert, 64'h62, 4'd1, 32'd2);
    send_request(ActInsert, 64'h63, 4'd1, 32'd3);
    send_request(ActSearch, 64'h63, 4'd1, '0);
    send_request(ActRemove, 64'h63, 4'd1, '0);
    send_request(ActRemove, 64'h61, 4'd1, '0);
    send_request(ActSearch, 64'h62, 4'd1, '0);
    send_request(ActInsert, 64'h63, 4'd1, 32'd3);
    send_request(ActSearch, 64'h63, 4'd1, '0);

    random_phase(11'd0,    150, 4,  1'b0);
    random_phase(11'd2047,  60, 40, 1'b0);
    random_phase(11'd3,    200, 6,  1'b1);
    random_phase(11'd7,    200, 10, 1'b0);
    random_phase(11'd16,   250, 24, 1'b0);
    random_phase(11'd31,   250, 40, 1'b0);
    random_phase(11'd64,   250, 64, 1'b0);
    random_phase(11'd100,  200, 64, 1'b0);
    random_phase(11'd1023,  60, 40, 1'b0);
    random_phase(11'd1,    150, 4,  1'b0);
    random_phase(11'd13,   250, 20, 1'b0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
